>>> hw/rtl/sssu_pkg.sv
`timescale 1ns / 1ps

package sssu_pkg;

  localparam int unsigned FrameBits  = 16;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned NumFrames  = 4;

  localparam int unsigned ValueW   = 16;
  localparam int unsigned SegW     = 8;
  localparam int unsigned DigW     = 4;
  localparam int unsigned HalfW    = 8;
  localparam int unsigned HoldW    = 24;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [CfgIdxW-1:0] CfgShiftHalfPeriod = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgDigitHoldCycles = 1'd1;

  localparam logic [HalfW-1:0] ShiftHalfPeriodRst = 8'd10;
  localparam logic [HoldW-1:0] DigitHoldCyclesRst = 24'd32000;

  localparam logic [SegW-1:0] GlyphB     = 8'h8F;
  localparam logic [SegW-1:0] GlyphD     = 8'hA3;
  localparam logic [SegW-1:0] GlyphDash  = 8'hBF;
  localparam logic [SegW-1:0] GlyphBlank = 8'hFF;

  localparam logic [DigW-1:0] DigitLeft = 4'b1000;

  // reciprocal of ten, exact for 16-bit operands after a shift by 19
  localparam logic [15:0] RecipTen      = 16'd52429;
  localparam int unsigned RecipTenShift = 19;

  typedef struct packed {
    logic [SegW-1:0] seg_hi;
    logic [SegW-1:0] seg_lo;
  } glyph_pair_t;

  typedef enum logic [1:0] {
    StIdle,
    StShift,
    StLoad,
    StHold
  } back_state_e;

  function automatic logic [SegW-1:0] glyph_of(input logic [3:0] code);
    logic [SegW-1:0] g;
    unique case (code)
      4'h0: g = 8'hC0;
      4'h1: g = 8'hF9;
      4'h2: g = 8'hA4;
      4'h3: g = 8'hB0;
      4'h4: g = 8'h99;
      4'h5: g = 8'h92;
      4'h6: g = 8'h82;
      4'h7: g = 8'hF8;
      4'h8: g = 8'h80;
      4'h9: g = 8'h90;
      4'hA: g = 8'h88;
      4'hB: g = 8'h83;
      4'hC: g = 8'hC6;
      4'hD: g = 8'hA1;
      4'hE: g = 8'h86;
      4'hF: g = 8'h8E;
      default: g = GlyphBlank;
    endcase
    return g;
  endfunction

endpackage

>>> hw/rtl/seven_segment_scan_shifter_unit.sv
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// in        input      in_valid_i / in_stall_o    in_value_i
// out       output     out_valid_o / out_stall_i  out_segment_code_o, out_digit_select_o,
//                                                 out_last_o
// cfg       input      cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// each input transaction yields four output transactions, one per digit frame
// a frame runs a shift state of 32 half-period phases (hp of zero counts as one), a load
// state and a hold state that ends when its count reaches digit_hold_cycles
// the frame sequencer sets the rate; a two-entry queue decouples the input side
// reset is asynchronous active low and restores both registers to their defaults
// a stalled output holds its frame and stretches the load cycle of the next one

module seven_segment_scan_shifter_unit #(
  parameter int unsigned QUEUE_DEPTH = sssu_pkg::QueueDepth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [sssu_pkg::ValueW-1:0] in_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [sssu_pkg::SegW-1:0]          out_segment_code_o,
  output logic [sssu_pkg::DigW-1:0]          out_digit_select_o,
  output logic                               out_last_o,
  input  logic                               cfg_we_i,
  input  logic [sssu_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [sssu_pkg::CfgDataW-1:0]      cfg_wdata_i
);
  import sssu_pkg::*;

  logic [HalfW-1:0] shift_half_period_q;
  logic [HoldW-1:0] digit_hold_cycles_q;

  glyph_pair_t push_data;
  glyph_pair_t pop_data;
  logic        push;
  logic        pop;
  logic        q_full;
  logic        q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_half_period_q <= ShiftHalfPeriodRst;
      digit_hold_cycles_q <= DigitHoldCyclesRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgShiftHalfPeriod: shift_half_period_q <= cfg_wdata_i[HalfW-1:0];
        CfgDigitHoldCycles: digit_hold_cycles_q <= cfg_wdata_i[HoldW-1:0];
        default: ;
      endcase
    end
  end

  sssu_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_value_i (in_value_i),
    .q_full_i   (q_full),
    .q_push_o   (push),
    .q_data_o   (push_data)
  );

  sssu_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  sssu_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .shift_half_period_i (shift_half_period_q),
    .digit_hold_cycles_i (digit_hold_cycles_q),
    .q_empty_i           (q_empty),
    .q_data_i            (pop_data),
    .q_pop_o             (pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_segment_code_o  (out_segment_code_o),
    .out_digit_select_o  (out_digit_select_o),
    .out_last_o          (out_last_o)
  );

endmodule

>>> hw/rtl/sssu_front.sv
`timescale 1ns / 1ps

module sssu_front (
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [sssu_pkg::ValueW-1:0] in_value_i,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output sssu_pkg::glyph_pair_t            q_data_o
);
  import sssu_pkg::*;

  logic [14:0] mag;
  logic [30:0] prod;
  logic [11:0] quot;
  logic [14:0] quot_x10;
  logic [14:0] rem_full;
  logic        show_dash;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  assign show_dash = in_value_i[ValueW-1] || (in_value_i == '0);
  assign mag       = in_value_i[14:0];

  // value % 10 by reciprocal multiply
  assign prod     = 31'(mag) * 31'(RecipTen);
  assign quot     = prod[30:RecipTenShift];
  assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign rem_full = mag - quot_x10;

  always_comb begin
    if (show_dash) begin
      q_data_o.seg_hi = GlyphDash;
      q_data_o.seg_lo = GlyphDash;
    end else begin
      q_data_o.seg_hi = glyph_of(in_value_i[11:8]);
      q_data_o.seg_lo = glyph_of(rem_full[3:0]);
    end
  end

endmodule

>>> hw/rtl/sssu_queue.sv
`timescale 1ns / 1ps

module sssu_queue #(
  parameter int unsigned Depth = sssu_pkg::QueueDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  sssu_pkg::glyph_pair_t push_data_i,
  input  logic                  pop_i,
  output sssu_pkg::glyph_pair_t pop_data_o,
  output logic                  full_o,
  output logic                  empty_o
);
  import sssu_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  glyph_pair_t     mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o     = (count_q == CntW'(Depth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hw/rtl/sssu_back.sv
`timescale 1ns / 1ps

module sssu_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [sssu_pkg::HalfW-1:0]    shift_half_period_i,
  input  logic [sssu_pkg::HoldW-1:0]    digit_hold_cycles_i,
  input  logic                          q_empty_i,
  input  sssu_pkg::glyph_pair_t         q_data_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sssu_pkg::SegW-1:0]     out_segment_code_o,
  output logic [sssu_pkg::DigW-1:0]     out_digit_select_o,
  output logic                          out_last_o
);
  import sssu_pkg::*;

  localparam int unsigned PhaseW   = $clog2(2 * FrameBits);
  localparam int unsigned FrameIdW = $clog2(NumFrames);

  back_state_e          state_q, state_d;
  glyph_pair_t          entry_q;
  logic [FrameIdW-1:0]  frame_q;
  logic [HalfW-1:0]     half_cnt_q;
  logic [PhaseW-1:0]    phase_q;
  logic [HoldW-1:0]     hold_cnt_q;
  logic                 out_valid_q;
  logic [SegW-1:0]      seg_q;
  logic [DigW-1:0]      dig_q;
  logic                 last_q;

  logic [HalfW-1:0]     half_lim;
  logic                 half_tick;
  logic                 shift_done;
  logic                 hold_done;
  logic                 frame_last;
  logic                 out_free;
  logic                 load_out;
  logic [SegW-1:0]      frame_seg;

  // a zero half period runs like a half period of one
  assign half_lim   = (shift_half_period_i == '0) ? '0 : shift_half_period_i - 1'b1;
  assign half_tick  = (half_cnt_q == half_lim);
  assign shift_done = half_tick && (phase_q == PhaseW'(2 * FrameBits - 1));
  assign hold_done  = (hold_cnt_q == digit_hold_cycles_i);
  assign frame_last = (frame_q == FrameIdW'(NumFrames - 1));
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    case (frame_q)
      2'd0:    frame_seg = GlyphB;
      2'd1:    frame_seg = GlyphD;
      2'd2:    frame_seg = entry_q.seg_hi;
      default: frame_seg = entry_q.seg_lo;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (!q_empty_i) state_d = StShift;
      StShift: if (shift_done) state_d = StLoad;
      StLoad:  if (out_free) state_d = StHold;
      StHold: begin
        if (hold_done) begin
          state_d = frame_last ? StIdle : StShift;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    q_pop_o  = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      StIdle:  q_pop_o  = !q_empty_i;
      StLoad:  load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      frame_q     <= '0;
      half_cnt_q  <= '0;
      phase_q     <= '0;
      hold_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (q_pop_o) begin
        frame_q    <= '0;
        half_cnt_q <= '0;
        phase_q    <= '0;
      end else if (state_q == StShift) begin
        if (half_tick) begin
          half_cnt_q <= '0;
          phase_q    <= phase_q + 1'b1;
        end else begin
          half_cnt_q <= half_cnt_q + 1'b1;
        end
      end else if (state_q == StHold) begin
        if (hold_done) begin
          frame_q    <= frame_q + 1'b1;
          half_cnt_q <= '0;
          phase_q    <= '0;
        end
      end

      if (load_out) begin
        hold_cnt_q <= '0;
      end else if (state_q == StHold && !hold_done) begin
        hold_cnt_q <= hold_cnt_q + 1'b1;
      end

      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      entry_q <= q_data_i;
    end
    if (load_out) begin
      seg_q  <= frame_seg;
      dig_q  <= DigitLeft >> frame_q;
      last_q <= frame_last;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_segment_code_o = seg_q;
  assign out_digit_select_o = dig_q;
  assign out_last_o         = last_q;

endmodule

>>> verif/scan_frame_monitor.sv
`timescale 1ns / 1ps

module scan_frame_monitor
  import sssu_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic signed [ValueW-1:0]  in_value_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [SegW-1:0]           out_segment_code_i,
  input  logic [DigW-1:0]           out_digit_select_i,
  input  logic                      out_last_i,
  output int                        mismatch_count_o,
  output int                        open_frames_o,
  output int                        levels_seen_o,
  output int                        frames_seen_o,
  output int                        dash_scans_o
);

  localparam logic [SegW-1:0] SegLetterB = 8'h8F;
  localparam logic [SegW-1:0] SegLetterD = 8'hA3;
  localparam logic [SegW-1:0] SegDash    = 8'hBF;

  localparam logic [DigW-1:0] DigFirst  = 4'b1000;
  localparam logic [DigW-1:0] DigSecond = 4'b0100;
  localparam logic [DigW-1:0] DigThird  = 4'b0010;
  localparam logic [DigW-1:0] DigFourth = 4'b0001;

  // glyph of hex digit d sits at bits d*8 +: 8
  localparam logic [16*SegW-1:0] HexGlyphs = {
    8'h8E, 8'h86, 8'hA1, 8'hC6, 8'h83, 8'h88, 8'h90, 8'h80,
    8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
  };

  typedef struct packed {
    logic [SegW-1:0] seg;
    logic [DigW-1:0] dig;
    logic            last;
  } scan_frame_t;

  scan_frame_t expected_frames[$];
  scan_frame_t want;
  scan_frame_t got;

  int mismatches  = 0;
  int open_frames = 0;
  int levels_seen = 0;
  int frames_seen = 0;
  int dash_scans  = 0;

  assign mismatch_count_o = mismatches;
  assign open_frames_o    = open_frames;
  assign levels_seen_o    = levels_seen;
  assign frames_seen_o    = frames_seen;
  assign dash_scans_o     = dash_scans;

  task automatic queue_scan(input logic signed [ValueW-1:0] level);
    logic [ValueW-1:0] raw;
    logic [SegW-1:0]   seg_third;
    logic [SegW-1:0]   seg_fourth;
    int unsigned       mid;
    int unsigned       low;
    raw = level;
    if (raw[ValueW-1] || raw == '0) begin
      seg_third  = SegDash;
      seg_fourth = SegDash;
      dash_scans++;
    end else begin
      mid        = (raw / 256) % 16;
      low        = raw % 10;
      seg_third  = HexGlyphs[mid*SegW +: SegW];
      seg_fourth = HexGlyphs[low*SegW +: SegW];
    end
    expected_frames.push_back(scan_frame_t'{SegLetterB, DigFirst, 1'b0});
    expected_frames.push_back(scan_frame_t'{SegLetterD, DigSecond, 1'b0});
    expected_frames.push_back(scan_frame_t'{seg_third, DigThird, 1'b0});
    expected_frames.push_back(scan_frame_t'{seg_fourth, DigFourth, 1'b1});
    open_frames += 4;
    levels_seen++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        queue_scan(in_value_i);
      end
      if (out_valid_i && !out_stall_i) begin
        frames_seen++;
        got = scan_frame_t'{out_segment_code_i, out_digit_select_i, out_last_i};
        if (expected_frames.size() == 0) begin
          $display("%0t: frame with nothing expected, seg %h dig %h last %b",
                   $time, got.seg, got.dig, got.last);
          mismatches++;
        end else begin
          want = expected_frames.pop_front();
          open_frames--;
          if (got.seg !== want.seg) begin
            $display("%0t: segment_code expected %h actual %h", $time, want.seg, got.seg);
            mismatches++;
          end
          if (got.dig !== want.dig) begin
            $display("%0t: digit_select expected %h actual %h", $time, want.dig, got.dig);
            mismatches++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, got.last);
            mismatches++;
          end
        end
      end
    end
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sssu_pkg::*;

  localparam int QuietLimit = 100000;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [ValueW-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [SegW-1:0]          out_segment_code;
  logic [DigW-1:0]          out_digit_select;
  logic                     out_last;
  logic                     cfg_we = 1'b0;
  logic [CfgIdxW-1:0]       cfg_idx = '0;
  logic [CfgDataW-1:0]      cfg_wdata = '0;

  int mismatch_count;
  int open_frames;
  int levels_seen;
  int frames_seen;
  int dash_scans;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  int settings_run = 0;
  int cur_half = ShiftHalfPeriodRst;
  int cur_hold = DigitHoldCyclesRst;

  always #4 clk_i = ~clk_i;

  seven_segment_scan_shifter_unit u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .in_value_i         (in_value),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .out_segment_code_o (out_segment_code),
    .out_digit_select_o (out_digit_select),
    .out_last_o         (out_last),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_wdata_i        (cfg_wdata)
  );

  scan_frame_monitor u_frame_monitor (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .in_value_i         (in_value),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .out_segment_code_i (out_segment_code),
    .out_digit_select_i (out_digit_select),
    .out_last_i         (out_last),
    .mismatch_count_o   (mismatch_count),
    .open_frames_o      (open_frames),
    .levels_seen_o      (levels_seen),
    .frames_seen_o      (frames_seen),
    .dash_scans_o       (dash_scans)
  );

  always @(negedge clk_i) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, QuietLimit);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a falling edge while the block is idle
  task automatic program_timing(input logic [CfgDataW-1:0] half_data,
                                input logic [CfgDataW-1:0] hold_data);
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgShiftHalfPeriod;
    cfg_wdata <= half_data;
    @(negedge clk_i);
    cfg_idx   <= CfgDigitHoldCycles;
    cfg_wdata <= hold_data;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    @(negedge clk_i);
    cur_half = half_data[HalfW-1:0];
    cur_hold = hold_data[HoldW-1:0];
    settings_run++;
  endtask

  task automatic send_level(input logic signed [ValueW-1:0] level);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_value <= ValueW'($urandom);
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_value <= level;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // last frame may still be in its hold time when it is accepted
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (open_frames != 0) @(negedge clk_i);
    repeat (32 * (cur_half == 0 ? 1 : cur_half) + cur_hold + 16) @(negedge clk_i);
  endtask

  function automatic logic signed [ValueW-1:0] random_level();
    logic signed [ValueW-1:0] level;
    case ($urandom_range(9))
      0:       level = ValueW'($signed($urandom_range(4)) - 2);
      1, 2:    level = ValueW'($urandom);
      default: level = ValueW'($urandom_range(32767, 1));
    endcase
    return level;
  endfunction

  task automatic run_phase(input logic [CfgDataW-1:0] half_data,
                           input logic [CfgDataW-1:0] hold_data,
                           input int idle_pct, input int stall_pct, input int count);
    program_timing(half_data, hold_data);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_level(random_level());
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // widest settings are only stored, then masked write back to the fastest
    program_timing(24'hFFFFFF, 24'hFFFFFF);
    program_timing(24'h5A5A01, 24'h000000);

    send_level(16'sd0);
    send_level(-16'sd1);
    send_level(16'sh8000);
    send_level(16'sd32767);
    send_level(16'sd1);
    // every third-digit code, every last digit
    for (int k = 0; k < 16; k++) begin
      send_level(ValueW'(k * 257 + 3));
    end
    wait_drained();

    run_phase(24'd0, 24'd3, 86, 0, 32);
    run_phase(24'd2, 24'd17, 0, 86, 32);
    run_phase(24'd1, 24'd0, 22, 22, 30);
    run_phase(24'd255, 24'd0, 0, 0, 2);
    run_phase(24'd3, 24'd1000, 22, 22, 3);

    $display("checked %0d scan frames from %0d levels over %0d timing settings",
             frames_seen, levels_seen, settings_run);
    $display("%0d scans showed dashes, %0d showed digits", dash_scans,
             levels_seen - dash_scans);
    if (mismatch_count == 0 && open_frames == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
